@@ design/dfd_pkg.sv @@
`timescale 1ns / 1ps

package dfd_pkg;

  localparam logic [7:0] HDR0    = 8'h5A;
  localparam logic [7:0] HDR1    = 8'hA5;
  localparam logic [7:0] CMD_VP  = 8'h83;
  localparam logic [7:0] CMD_ACK = 8'h82;
  localparam logic [7:0] OK0     = 8'h4F;
  localparam logic [7:0] OK1     = 8'h4B;

  typedef enum logic [1:0] {
    KIND_VP      = 2'd0,
    KIND_ACK_OK  = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // what the back end has to emit for one queued job
  typedef enum logic [1:0] {
    OP_ONE  = 2'd0,  // a single result
    OP_HDR3 = 2'd1,  // 5A A5 00, zero-length frame
    OP_HDR4 = 2'd2   // 5A A5 len cmd, unknown command replay
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       has;
    logic [7:0] data;
    logic [7:0] len;
    logic       last;
    kind_e      kind;
  } job_t;

endpackage

@@ design/display_frame_deframer.sv @@
`timescale 1ns / 1ps

// channel | valid       | ready       | payload
// input   | in_valid_i  | in_ready_o  | rx_byte_i
// output  | out_valid_o | out_ready_i | has_byte_o out_byte_o last_o msg_kind_o
//
// the front end parses one byte per cycle and pushes a job into a 4-entry queue
// the back end expands each job into 1 to 4 results, one per cycle, into a
// registered output slot; a header replay yields 3 or 4 results
// input stalls only when the job queue is full; output stalls back up into it
// asynchronous active-low reset returns the parser to header hunt, queue empty

module display_frame_deframer import dfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic [1:0] msg_kind_o
);

  logic push, full, q_valid, pop;
  job_t job_in, job_out;

  dfd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .rx_byte_i, .in_ready_o,
    .q_full_i(full), .push_o(push), .job_o(job_in)
  );

  dfd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(full),
    .valid_o(q_valid), .job_o(job_out), .pop_i(pop)
  );

  dfd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .job_i(job_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .has_byte_o, .out_byte_o, .last_o, .msg_kind_o
  );

endmodule

@@ design/dfd_front.sv @@
`timescale 1ns / 1ps

module dfd_front import dfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_DATA  = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] left_q, left_d;
  logic [7:0] cmd_q, cmd_d;
  logic [1:0] ok_q, ok_d;
  logic       fire;
  logic       gen;
  logic [7:0] pos;
  logic       known;
  logic       done;

  function automatic kind_e final_kind(logic [7:0] cmd, logic [7:0] len, logic [1:0] ok);
    kind_e k;
    if (cmd == CMD_VP) k = KIND_VP;
    else if (cmd == CMD_ACK) k = (len == 8'd3 && ok == 2'd2) ? KIND_ACK_OK : KIND_ACK;
    else k = KIND_UNKNOWN;
    return k;
  endfunction

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign push_o     = fire && gen;
  assign pos        = len_q - 8'd1 - left_q;
  assign known      = (rx_byte_i == CMD_VP) || (rx_byte_i == CMD_ACK);
  assign done       = (len_q == 8'd1);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    left_d  = left_q;
    cmd_d   = cmd_q;
    ok_d    = ok_q;
    gen     = 1'b0;
    job_o   = '{op: OP_ONE, has: 1'b1, data: rx_byte_i, len: len_q, last: 1'b0,
                kind: KIND_VP};
    case (phase_q)
      PH_HUNT1: begin
        if (rx_byte_i == HDR1) phase_d = PH_LEN;
        else if (rx_byte_i == HDR0) phase_d = PH_HUNT1;
        else phase_d = PH_HUNT0;
      end
      PH_LEN: begin
        len_d = rx_byte_i;
        if (rx_byte_i == 8'd0) begin
          gen        = 1'b1;
          job_o.op   = OP_HDR3;
          job_o.last = 1'b1;
          job_o.kind = KIND_UNKNOWN;
          phase_d    = PH_HUNT0;
        end else begin
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_d   = rx_byte_i;
        ok_d    = 2'd0;
        left_d  = len_q - 8'd1;
        phase_d = done ? PH_HUNT0 : PH_DATA;
        if (known) begin
          gen        = done;
          job_o.has  = 1'b0;
          job_o.data = 8'd0;
          job_o.last = 1'b1;
          job_o.kind = final_kind(rx_byte_i, len_q, 2'd0);
        end else begin
          gen        = 1'b1;
          job_o.op   = OP_HDR4;
          job_o.last = done;
          job_o.kind = KIND_UNKNOWN;
        end
      end
      PH_DATA: begin
        if (pos == 8'd0) ok_d = (rx_byte_i == OK0) ? 2'd1 : 2'd0;
        else if (pos == 8'd1) ok_d = (ok_q == 2'd1 && rx_byte_i == OK1) ? 2'd2 : 2'd0;
        else ok_d = 2'd0;
        left_d     = left_q - 8'd1;
        gen        = 1'b1;
        job_o.last = (left_d == 8'd0);
        job_o.kind = (left_d == 8'd0) ? final_kind(cmd_q, len_q, ok_d) : KIND_VP;
        if (left_d == 8'd0) phase_d = PH_HUNT0;
      end
      default: begin
        phase_d = (rx_byte_i == HDR0) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT0;
      len_q   <= 8'd0;
      left_q  <= 8'd0;
      cmd_q   <= 8'd0;
      ok_q    <= 2'd0;
    end else if (fire) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      cmd_q   <= cmd_d;
      ok_q    <= ok_d;
    end
  end

endmodule

@@ design/dfd_queue.sv @@
`timescale 1ns / 1ps

module dfd_queue import dfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int Depth = 4;

  job_t       mem_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'(Depth));
  assign valid_o = (cnt_q != 3'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !valid_o))
    else $error("pop from empty queue");

endmodule

@@ design/dfd_back.sv @@
`timescale 1ns / 1ps

module dfd_back import dfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic [1:0] msg_kind_o
);

  logic [1:0] idx_q;
  logic       ov_q;
  logic       has_q, last_q;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       load;
  logic       fin;
  logic       r_has, r_last;
  logic [7:0] r_byte;
  kind_e      r_kind;

  always_comb begin
    r_has  = 1'b1;
    r_byte = HDR0;
    r_last = 1'b0;
    r_kind = KIND_VP;
    fin    = 1'b0;
    case (job_i.op)
      OP_ONE: begin
        r_has  = job_i.has;
        r_byte = job_i.data;
        r_last = job_i.last;
        r_kind = job_i.kind;
        fin    = 1'b1;
      end
      OP_HDR3: begin
        case (idx_q)
          2'd0:    r_byte = HDR0;
          2'd1:    r_byte = HDR1;
          default: begin
            r_byte = 8'd0;
            r_last = 1'b1;
            r_kind = KIND_UNKNOWN;
            fin    = 1'b1;
          end
        endcase
      end
      OP_HDR4: begin
        case (idx_q)
          2'd0:    r_byte = HDR0;
          2'd1:    r_byte = HDR1;
          2'd2:    r_byte = job_i.len;
          default: begin
            r_byte = job_i.data;
            r_last = job_i.last;
            r_kind = job_i.last ? KIND_UNKNOWN : KIND_VP;
            fin    = 1'b1;
          end
        endcase
      end
      default: fin = 1'b1;
    endcase
  end

  // output slot is free when empty or being drained this cycle
  assign load  = q_valid_i && (!ov_q || out_ready_i);
  assign pop_o = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) idx_q <= fin ? 2'd0 : idx_q + 2'd1;
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      has_q  <= r_has;
      byte_q <= r_byte;
      last_q <= r_last;
      kind_q <= r_kind;
    end
  end

  assign out_valid_o = ov_q;
  assign has_byte_o  = has_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign msg_kind_o  = kind_q;

endmodule

@@ test/tb_display_frame_deframer.sv @@
`timescale 1ns / 1ps

module tb_display_frame_deframer;
  import dfd_pkg::*;

  localparam int LONG_HOLD  = 120;
  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_ITEMS = 260;

  typedef enum logic [2:0] {
    SEEK_SYNC0,
    SEEK_SYNC1,
    GET_LEN,
    GET_CMD,
    GET_DATA
  } parse_e;

  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       last;
    kind_e      kind;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       has_byte_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic [1:0] msg_kind_o;

  display_frame_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .has_byte_o  (has_byte_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .msg_kind_o  (msg_kind_o)
  );

  // parser mirror
  parse_e     rx_phase  = SEEK_SYNC0;
  logic [7:0] rx_len    = '0;
  logic [7:0] rx_left   = '0;
  logic [7:0] rx_cmd    = '0;
  logic [1:0] rx_ok     = '0;

  result_t pending_results[$];
  int      error_count  = 0;
  int      bytes_sent   = 0;
  int      quiet_cycles = 0;
  bit      src_steady   = 1'b0;
  bit      sink_steady  = 1'b0;
  bit      sink_hold    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic kind_e closing_kind();
    if (rx_cmd == CMD_VP) return KIND_VP;
    if (rx_cmd == CMD_ACK) return (rx_len == 8'd3 && rx_ok == 2'd2) ? KIND_ACK_OK : KIND_ACK;
    return KIND_UNKNOWN;
  endfunction

  function automatic void push_result(logic has, logic [7:0] data, logic last, kind_e kind);
    result_t r;
    r.has  = has;
    r.data = data;
    r.last = last;
    r.kind = last ? kind : KIND_VP;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_frame_byte(logic [7:0] b);
    logic [7:0] pos;
    case (rx_phase)
      SEEK_SYNC1: begin
        if (b == HDR1) rx_phase = GET_LEN;
        else if (b == HDR0) rx_phase = SEEK_SYNC1;
        else rx_phase = SEEK_SYNC0;
      end
      GET_LEN: begin
        rx_len = b;
        if (b == 8'd0) begin
          // zero length: header bytes come back as an unknown message
          push_result(1'b1, HDR0, 1'b0, KIND_VP);
          push_result(1'b1, HDR1, 1'b0, KIND_VP);
          push_result(1'b1, 8'h00, 1'b1, KIND_UNKNOWN);
          rx_phase = SEEK_SYNC0;
        end else begin
          rx_phase = GET_CMD;
        end
      end
      GET_CMD: begin
        rx_cmd  = b;
        rx_ok   = 2'd0;
        rx_left = rx_len - 8'd1;
        if (b == CMD_VP || b == CMD_ACK) begin
          if (rx_len == 8'd1) push_result(1'b0, 8'h00, 1'b1, closing_kind());
        end else begin
          push_result(1'b1, HDR0, 1'b0, KIND_VP);
          push_result(1'b1, HDR1, 1'b0, KIND_VP);
          push_result(1'b1, rx_len, 1'b0, KIND_VP);
          push_result(1'b1, b, rx_len == 8'd1, KIND_UNKNOWN);
        end
        rx_phase = (rx_len == 8'd1) ? SEEK_SYNC0 : GET_DATA;
      end
      GET_DATA: begin
        pos = rx_len - 8'd1 - rx_left;
        if (pos == 8'd0) rx_ok = (b == OK0) ? 2'd1 : 2'd0;
        else if (pos == 8'd1) rx_ok = (rx_ok == 2'd1 && b == OK1) ? 2'd2 : 2'd0;
        else rx_ok = 2'd0;
        rx_left = rx_left - 8'd1;
        if (rx_left == 8'd0) begin
          push_result(1'b1, b, 1'b1, closing_kind());
          rx_phase = SEEK_SYNC0;
        end else begin
          push_result(1'b1, b, 1'b0, KIND_VP);
        end
      end
      default: rx_phase = (b == HDR0) ? SEEK_SYNC1 : SEEK_SYNC0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    end
  endtask

  // both handshakes sampled on the same edge, predictor first
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_frame_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, out_byte", out_byte_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (has_byte_o !== want.has) report_mismatch("has_byte", has_byte_o, want.has);
          if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
          if (msg_kind_o !== want.kind) report_mismatch("msg_kind", msg_kind_o, want.kind);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("display_frame_deframer regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin : sink_proc
    int n;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        sink_hold = 1'b0;
      end else begin
        n = sink_steady ? 0 : idle_gap();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // valid stays up across back-to-back transfers, dropped only for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit ok_body);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(len);
    if (len != 8'd0) begin
      send_byte(cmd);
      for (int i = 0; i < int'(len) - 1; i++) begin
        if (ok_body && i == 0) send_byte(OK0);
        else if (ok_body && i == 1) send_byte(OK1);
        else send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_header_hunt();
    // junk, a repeated 5A that restarts the hunt, then vp data with extreme bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR0);
    send_byte(HDR0);
    send_byte(HDR1);
    send_byte(8'd3);
    send_byte(CMD_VP);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_known_commands();
    send_frame(CMD_ACK, 8'd3, 1'b1);
    send_frame(CMD_ACK, 8'd1, 1'b0);
    send_frame(CMD_VP, 8'd1, 1'b0);
  endtask

  task automatic test_short_frames();
    send_frame(8'h00, 8'd0, 1'b0);
    send_frame(8'hFF, 8'd1, 1'b0);
  endtask

  task automatic test_random_frames();
    int         r;
    logic [7:0] cmd;
    logic [7:0] len;
    bit         ok_body;
    bit         long_done;
    long_done = 1'b0;
    while (bytes_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        src_steady  = $urandom_range(0, 1);
        sink_steady = $urandom_range(0, 1);
      end
      // occasional noise, biased toward stray header bytes
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, 3);
          send_byte(r == 0 ? HDR0 : (r == 1 ? HDR1 : 8'($urandom_range(0, 255))));
        end
      end
      r = $urandom_range(0, 9);
      cmd = (r < 4) ? CMD_VP : (r < 7) ? CMD_ACK : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (!long_done && bytes_sent > RAND_ITEMS / 2) begin
        len = 8'($urandom_range(128, 150));
        long_done = 1'b1;
      end else if (r < 6) len = 8'd0;
      else if (r < 20) len = 8'd1;
      else if (r < 90) len = 8'($urandom_range(2, 6));
      else len = 8'($urandom_range(7, 40));
      ok_body = 1'b0;
      if (cmd == CMD_ACK && $urandom_range(0, 1) == 1) begin
        ok_body = 1'b1;
        if ($urandom_range(0, 3) != 0) len = 8'd3;
      end
      if (len < 8'd2) ok_body = 1'b0;
      send_frame(cmd, len, ok_body);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    // replays fill the job queue while the output is held off
    src_steady = 1'b1;
    sink_hold  = 1'b1;
    repeat (5) send_frame(8'h11, 8'd1, 1'b0);
    send_frame(CMD_VP, 8'd4, 1'b0);
    src_steady = 1'b0;
  endtask

  initial begin : main
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_hunt();
    test_known_commands();
    test_short_frames();
    test_backpressure();
    test_random_frames();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (pending_results.size() != 0) report_mismatch("results left over", pending_results.size(), 0);

    if (error_count == 0) begin
      $display("display_frame_deframer regression: pass");
    end else begin
      $display("display_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule

@@ display_frame_deframer.f @@
design/dfd_pkg.sv
design/dfd_front.sv
design/dfd_queue.sv
design/dfd_back.sv
design/display_frame_deframer.sv
test/tb_display_frame_deframer.sv
